FILE: sv/vsa_pkg.sv
// Package for the voice slot allocator: request codes, defaults and sizing helpers.
package vsa_pkg;

  // Default pool size and priority width
  localparam int unsigned SlotsDefault        = 64;
  localparam int unsigned PriorityBitsDefault = 16;

  // Fixed field widths
  localparam int unsigned ActiveW = 7;
  localparam int unsigned TagW    = 8;
  localparam int unsigned IdxW    = 6;

  // Reset value of the active slot count
  localparam logic [ActiveW-1:0] ActiveReset = 7'd64;

  // Request codes; code 3 is unused and rejected
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_FINISH  = 2'd2
  } req_type_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_e;

  // Width of an index into a store of the given depth
  function automatic int unsigned idx_bits(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: sv/vsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [vsa_pkg::idx_bits(DEPTH)-1:0]     waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [vsa_pkg::idx_bits(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/voice_slot_allocator_core.sv
// Voice slot allocator: allocate, release and finished-mark updates over a slot pool.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  request | in_valid_i / in_ready_o, req_type_i .. finished_i | in
//  result  | out_valid_o / out_ready_i, granted_o .. status_o   | out
//  config  | cfg_we_i, cfg_wdata_i (active_slots)             | in
//
// Allocate walks the pool one slot per cycle through the owner/priority RAM
// read port, stopping early when an idle slot turns up. Release and finished
// updates skip the walk. One item is in flight at a time; the result register
// lets a new item be taken while the previous result waits. Reset clears all
// busy and finished marks at once; owner and priority entries are only used
// for busy slots.
module voice_slot_allocator_core #(
  parameter int unsigned SLOTS         = vsa_pkg::SlotsDefault,
  parameter int unsigned PRIORITY_BITS = vsa_pkg::PriorityBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [vsa_pkg::ActiveW-1:0]         cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          req_type_i,
  input  logic [vsa_pkg::TagW-1:0]            owner_tag_i,
  input  logic signed [PRIORITY_BITS-1:0]     priority_req_i,
  input  logic [vsa_pkg::IdxW-1:0]            slot_index_i,
  input  logic                                finished_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                granted_o,
  output logic [vsa_pkg::IdxW-1:0]            granted_slot_o,
  output logic                                evicted_o,
  output logic [vsa_pkg::TagW-1:0]            evicted_owner_o,
  output logic                                status_o
);

  localparam int unsigned IW   = vsa_pkg::idx_bits(SLOTS);
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned TW   = vsa_pkg::TagW;
  localparam int unsigned RAMW = TW + PRIORITY_BITS;

  vsa_pkg::state_e state_q, state_d;

  // configuration and slot flags
  logic [vsa_pkg::ActiveW-1:0] active_q;
  logic [SLOTS-1:0]            busy_q, done_q;

  // captured request
  logic [1:0]                      req_q;
  logic [TW-1:0]                   tag_q;
  logic signed [PRIORITY_BITS-1:0] prio_q;
  logic [vsa_pkg::IdxW-1:0]        sidx_q;
  logic                            fin_q;

  // scan state
  logic [CW-1:0]                   cnt_q;
  logic                            rd_vld_q;
  logic [IW-1:0]                   rd_idx_q;
  logic                            idle_hit_q;
  logic [IW-1:0]                   idle_idx_q;
  logic                            have_min_q, have_done_q;
  logic signed [PRIORITY_BITS-1:0] min_prio_q;
  logic [IW-1:0]                   min_idx_q, done_idx_q;
  logic [TW-1:0]                   min_own_q, done_own_q;

  // result register
  logic                            out_valid_q;
  logic                            gr_q, ev_q, st_q;
  logic [vsa_pkg::IdxW-1:0]        gslot_q;
  logic [TW-1:0]                   eown_q;

  logic [CW-1:0]                   pool_n;
  logic                            accept, out_free, scan_live, scan_end;
  logic [IW-1:0]                   cnt_idx, req_idx;
  logic                            req_in_range;
  logic [RAMW-1:0]                 rd_data;
  logic [TW-1:0]                   rd_own;
  logic signed [PRIORITY_BITS-1:0] rd_prio;

  // result of the finished item
  logic                            r_gr, r_ev, r_st;
  logic [IW-1:0]                   r_slot;
  logic [TW-1:0]                   r_own;
  logic                            ram_we;

  // Effective pool size
  assign pool_n = (32'(active_q) > SLOTS) ? CW'(SLOTS) : CW'(active_q);

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign cnt_idx   = cnt_q[IW-1:0];
  assign scan_end  = (cnt_q >= pool_n);
  assign scan_live = (state_q == vsa_pkg::ST_SCAN) && !scan_end;
  assign req_idx   = IW'(sidx_q);
  assign req_in_range = (32'(sidx_q) < 32'(pool_n)) && busy_q[req_idx];

  assign rd_own  = rd_data[RAMW-1 -: TW];
  assign rd_prio = signed'(rd_data[PRIORITY_BITS-1:0]);

  // Owner and priority store
  vsa_ram #(
    .WIDTH (RAMW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (r_slot),
    .wdata_i ({tag_q, prio_q}),
    .raddr_i (cnt_idx),
    .rdata_o (rd_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vsa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (req_type_i == vsa_pkg::REQ_ALLOC) ? vsa_pkg::ST_SCAN
                                                       : vsa_pkg::ST_RESP;
        end
      end
      vsa_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = vsa_pkg::ST_DRAIN;
        end else if (!busy_q[cnt_idx]) begin
          state_d = vsa_pkg::ST_RESP;
        end
      end
      vsa_pkg::ST_DRAIN: state_d = vsa_pkg::ST_RESP;
      vsa_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = vsa_pkg::ST_IDLE;
        end
      end
      default: state_d = vsa_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: result of the item under way
  always_comb begin
    r_gr   = 1'b0;
    r_ev   = 1'b0;
    r_st   = 1'b0;
    r_slot = '0;
    r_own  = '0;
    ram_we = 1'b0;
    unique case (req_q)
      vsa_pkg::REQ_ALLOC: begin
        priority if (idle_hit_q) begin
          r_gr   = 1'b1;
          r_slot = idle_idx_q;
        end else if (have_done_q) begin
          r_gr   = 1'b1;
          r_ev   = 1'b1;
          r_slot = done_idx_q;
          r_own  = done_own_q;
        end else if (have_min_q) begin
          r_gr   = 1'b1;
          r_ev   = 1'b1;
          r_slot = min_idx_q;
          r_own  = min_own_q;
        end
      end
      vsa_pkg::REQ_RELEASE, vsa_pkg::REQ_FINISH: r_st = !req_in_range;
      default: r_st = 1'b1;
    endcase
    if (state_q != vsa_pkg::ST_RESP || !out_free) begin
      ram_we = 1'b0;
    end else begin
      ram_we = r_gr;
    end
  end

  // Control registers: state, config, flags, read valid, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsa_pkg::ST_IDLE;
      active_q    <= vsa_pkg::ActiveReset;
      busy_q      <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_live && busy_q[cnt_idx];
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      // commit the item, else drop the result once taken
      if (state_q == vsa_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
        if (r_gr) begin
          busy_q[r_slot] <= 1'b1;
          done_q[r_slot] <= 1'b0;
        end else if (!r_st && req_q == vsa_pkg::REQ_RELEASE) begin
          busy_q[req_idx] <= 1'b0;
          done_q[req_idx] <= 1'b0;
        end else if (!r_st && req_q == vsa_pkg::REQ_FINISH) begin
          done_q[req_idx] <= fin_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, scan walk and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= req_type_i;
      tag_q       <= owner_tag_i;
      prio_q      <= priority_req_i;
      sidx_q      <= slot_index_i;
      fin_q       <= finished_i;
      cnt_q       <= '0;
      idle_hit_q  <= 1'b0;
      have_min_q  <= 1'b0;
      have_done_q <= 1'b0;
    end else begin
      if (scan_live) begin
        cnt_q <= cnt_q + CW'(1);
        if (!busy_q[cnt_idx]) begin
          idle_hit_q <= 1'b1;
          idle_idx_q <= cnt_idx;
        end
      end
      // compare stage on the slot read last cycle
      if (rd_vld_q) begin
        if (done_q[rd_idx_q]) begin
          have_done_q <= 1'b1;
          done_idx_q  <= rd_idx_q;
          done_own_q  <= rd_own;
        end
        if (!have_min_q || rd_prio < min_prio_q) begin
          have_min_q <= 1'b1;
          min_prio_q <= rd_prio;
          min_idx_q  <= rd_idx_q;
          min_own_q  <= rd_own;
        end
      end
    end
    rd_idx_q <= cnt_idx;
    if (state_q == vsa_pkg::ST_RESP && out_free) begin
      gr_q    <= r_gr;
      ev_q    <= r_ev;
      st_q    <= r_st;
      gslot_q <= vsa_pkg::IdxW'(r_slot);
      eown_q  <= r_own;
    end
  end

  assign in_ready_o      = (state_q == vsa_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign granted_o       = gr_q;
  assign granted_slot_o  = gslot_q;
  assign evicted_o       = ev_q;
  assign evicted_owner_o = eown_q;
  assign status_o        = st_q;

endmodule

FILE: sv/vsa_checker.sv
// Port-level checker for the voice slot allocator, bound to the top level.
module vsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         granted_o,
  input logic [vsa_pkg::IdxW-1:0]     granted_slot_o,
  input logic                         evicted_o,
  input logic [vsa_pkg::TagW-1:0]     evicted_owner_o,
  input logic                         status_o
);

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

  // an eviction only comes with a grant, never with a rejection
  a_evict_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> granted_o && !status_o)
    else $error("eviction without grant");

  // unused result fields stay zero
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> granted_slot_o == '0 && evicted_owner_o == '0)
    else $error("stray result field");

endmodule

bind voice_slot_allocator_core vsa_checker u_vsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .granted_o       (granted_o),
  .granted_slot_o  (granted_slot_o),
  .evicted_o       (evicted_o),
  .evicted_owner_o (evicted_owner_o),
  .status_o        (status_o)
);

FILE: tb/sv/voice_slot_allocator_core_tb.sv
// Self-checking testbench for the voice slot allocator core.
`timescale 1ns / 1ps

module voice_slot_allocator_core_tb;

  localparam int unsigned Slots        = vsa_pkg::SlotsDefault;
  localparam int unsigned PrioW        = vsa_pkg::PriorityBitsDefault;
  localparam int unsigned TagW         = vsa_pkg::TagW;
  localparam int unsigned IdxW         = vsa_pkg::IdxW;
  localparam int unsigned ActiveW      = vsa_pkg::ActiveW;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 2 * (Slots + 3);
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned ReportLimit  = 10;
  // Request code with no meaning; the block must reject it
  localparam logic [1:0]  ReqUnused    = 2'd3;

  // One result item as the block reports it
  typedef struct packed {
    logic              granted;
    logic [IdxW-1:0]   gslot;
    logic              evicted;
    logic [TagW-1:0]   eowner;
    logic              status;
  } outcome_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [ActiveW-1:0]      cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              req_type_i = vsa_pkg::REQ_ALLOC;
  logic [TagW-1:0]         owner_tag_i = '0;
  logic signed [PrioW-1:0] priority_req_i = '0;
  logic [IdxW-1:0]         slot_index_i = '0;
  logic                    finished_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    granted_o;
  logic [IdxW-1:0]         granted_slot_o;
  logic                    evicted_o;
  logic [TagW-1:0]         evicted_owner_o;
  logic                    status_o;

  // Shadow copy of the slot pool
  logic                    slot_taken [Slots];
  logic                    slot_spent [Slots];
  logic [TagW-1:0]         slot_tag   [Slots];
  logic signed [PrioW-1:0] slot_prio  [Slots];
  logic [ActiveW-1:0]      pool_limit;

  outcome_t    pending_outcomes [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold   = 0;
  bit          no_idle     = 1'b0;

  voice_slot_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .owner_tag_i     (owner_tag_i),
    .priority_req_i  (priority_req_i),
    .slot_index_i    (slot_index_i),
    .finished_i      (finished_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .granted_o       (granted_o),
    .granted_slot_o  (granted_slot_o),
    .evicted_o       (evicted_o),
    .evicted_owner_o (evicted_owner_o),
    .status_o        (status_o)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Expected outcome of one request; updates the shadow pool
  function automatic outcome_t predict_slot_outcome(logic [1:0] kind,
                                                     logic [TagW-1:0] tag,
                                                     logic signed [PrioW-1:0] prio,
                                                     logic [IdxW-1:0] idx, logic fin);
    outcome_t                o;
    int unsigned             pool;
    int                      pick;
    int                      spent_at;
    int                      low_at;
    logic signed [PrioW-1:0] low_prio;
    o        = '0;
    pool     = (pool_limit > Slots) ? Slots : pool_limit;
    pick     = -1;
    spent_at = -1;
    low_at   = -1;
    low_prio = '0;
    if (kind == vsa_pkg::REQ_ALLOC) begin
      // first idle slot; on the way note last finished and first lowest priority
      for (int i = 0; i < pool; i++) begin
        if (!slot_taken[i]) begin
          pick = i;
          break;
        end
        if (slot_spent[i]) spent_at = i;
        if (low_at < 0 || slot_prio[i] < low_prio) begin
          low_at   = i;
          low_prio = slot_prio[i];
        end
      end
      if (pick < 0 && pool > 0) begin
        pick      = (spent_at >= 0) ? spent_at : low_at;
        o.evicted = 1'b1;
        o.eowner  = slot_tag[pick];
      end
      if (pick >= 0) begin
        slot_taken[pick] = 1'b1;
        slot_spent[pick] = 1'b0;
        slot_tag[pick]   = tag;
        slot_prio[pick]  = prio;
        o.granted        = 1'b1;
        o.gslot          = pick[IdxW-1:0];
      end
    end else if (kind == vsa_pkg::REQ_RELEASE || kind == vsa_pkg::REQ_FINISH) begin
      if (idx >= pool || !slot_taken[idx]) begin
        o.status = 1'b1;
      end else if (kind == vsa_pkg::REQ_RELEASE) begin
        slot_taken[idx] = 1'b0;
        slot_spent[idx] = 1'b0;
      end else begin
        slot_spent[idx] = fin;
      end
    end else begin
      o.status = 1'b1;
    end
    return o;
  endfunction

  // Offer one item and record its expected outcome once accepted
  task automatic send_request(logic [1:0] kind, logic [TagW-1:0] tag,
                              logic signed [PrioW-1:0] prio, logic [IdxW-1:0] idx, logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    owner_tag_i    <= tag;
    priority_req_i <= prio;
    slot_index_i   <= idx;
    finished_i     <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(predict_slot_outcome(kind, tag, prio, idx, fin));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_quiet();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Change the pool size with the block idle
  task automatic write_pool_size(logic [ActiveW-1:0] value);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_limit  = value;
  endtask

  // Result side: random stalls plus an occasional long hold-off
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold != 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] unexpected result: g=%0b s=%0d e=%0b o=%0h st=%0b",
                   $realtime, granted_o, granted_slot_o, evicted_o, evicted_owner_o, status_o);
      end else begin
        want = pending_outcomes.pop_front();
        if (granted_o !== want.granted || granted_slot_o !== want.gslot ||
            evicted_o !== want.evicted || evicted_owner_o !== want.eowner ||
            status_o !== want.status) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("[%0t] exp g=%0b s=%0d e=%0b o=%0h st=%0b got g=%0b s=%0d e=%0b o=%0h st=%0b",
                     $realtime, want.granted, want.gslot, want.evicted, want.eowner,
                     want.status, granted_o, granted_slot_o, evicted_o, evicted_owner_o,
                     status_o);
        end
      end
    end
  end

  // Fill a three-slot pool, then steal by lowest priority (ties go to the first)
  task automatic test_fill_and_steal();
    write_pool_size(7'd3);
    send_request(vsa_pkg::REQ_ALLOC, 8'h00, -16'sd32768, '0, 1'b0);
    send_request(vsa_pkg::REQ_ALLOC, 8'hFF, 16'sd32767, '0, 1'b0);
    send_request(vsa_pkg::REQ_ALLOC, 8'h5A, -16'sd32768, '0, 1'b0);
    send_request(vsa_pkg::REQ_ALLOC, 8'h11, 16'sd0, '0, 1'b0);
    send_request(vsa_pkg::REQ_ALLOC, 8'h22, 16'sd1, '0, 1'b0);
  endtask

  // Finished marks: highest finished slot is stolen first, clears on reuse and release
  task automatic test_finished_marks();
    send_request(vsa_pkg::REQ_FINISH, '0, '0, 6'd1, 1'b1);
    send_request(vsa_pkg::REQ_FINISH, '0, '0, 6'd0, 1'b1);
    send_request(vsa_pkg::REQ_ALLOC, 8'h33, -16'sd5, '0, 1'b0);
    send_request(vsa_pkg::REQ_FINISH, '0, '0, 6'd0, 1'b0);
    send_request(vsa_pkg::REQ_ALLOC, 8'h44, 16'sd7, '0, 1'b0);
    send_request(vsa_pkg::REQ_FINISH, '0, '0, 6'd2, 1'b1);
    send_request(vsa_pkg::REQ_RELEASE, '0, '0, 6'd2, 1'b0);
    send_request(vsa_pkg::REQ_ALLOC, 8'h55, 16'sd100, '0, 1'b0);
    send_request(vsa_pkg::REQ_ALLOC, 8'h66, 16'sd2, '0, 1'b0);
  endtask

  // Idle slots, slots beyond the pool and the unused code are all rejected
  task automatic test_bad_requests();
    send_request(vsa_pkg::REQ_RELEASE, '0, '0, 6'd1, 1'b0);
    send_request(vsa_pkg::REQ_RELEASE, '0, '0, 6'd1, 1'b0);
    send_request(vsa_pkg::REQ_FINISH, 8'hFF, '1, 6'd1, 1'b1);
    send_request(vsa_pkg::REQ_FINISH, '0, '0, 6'd63, 1'b1);
    send_request(vsa_pkg::REQ_RELEASE, '0, '0, 6'd3, 1'b0);
    send_request(ReqUnused, 8'hFF, -16'sd1, 6'd63, 1'b1);
  endtask

  // Pool size zero: nothing can be granted or addressed
  task automatic test_empty_pool();
    write_pool_size(7'd0);
    send_request(vsa_pkg::REQ_ALLOC, 8'h77, 16'sd9, '0, 1'b0);
    send_request(vsa_pkg::REQ_RELEASE, '0, '0, 6'd0, 1'b0);
  endtask

  // Result side held off while the sender keeps offering items
  task automatic test_backpressure();
    write_pool_size(7'd8);
    sink_hold = HoldCycles;
    no_idle   = 1'b1;
    for (int i = 0; i < 16; i++)
      send_request(vsa_pkg::REQ_ALLOC, 8'($urandom), 16'($urandom), '0, 1'b0);
    no_idle = 1'b0;
  endtask

  // Random traffic, mostly well-formed: allocations and updates of live slots
  task automatic test_random_traffic(int unsigned count, logic [ActiveW-1:0] size);
    int unsigned             r;
    int unsigned             pool;
    logic [1:0]              kind;
    logic signed [PrioW-1:0] prio;
    logic [IdxW-1:0]         idx;
    write_pool_size(size);
    pool = (size > Slots) ? Slots : size;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(49) == 0) no_idle = !no_idle;
      r = $urandom_range(99);
      if (r < 50)      kind = vsa_pkg::REQ_ALLOC;
      else if (r < 68) kind = vsa_pkg::REQ_RELEASE;
      else if (r < 95) kind = vsa_pkg::REQ_FINISH;
      else             kind = ReqUnused;
      // small priorities make ties common
      if ($urandom_range(3) == 0) prio = PrioW'($urandom_range(2)) - PrioW'(1);
      else                        prio = 16'($urandom);
      if (pool > 0 && $urandom_range(99) < 85) idx = IdxW'($urandom_range(pool - 1));
      else                                    idx = IdxW'($urandom_range(Slots - 1));
      send_request(kind, 8'($urandom), prio, idx, 1'($urandom));
    end
    no_idle = 1'b0;
  endtask

  // Test sequence
  initial begin : test_main
    for (int i = 0; i < Slots; i++) begin
      slot_taken[i] = 1'b0;
      slot_spent[i] = 1'b0;
      slot_tag[i]   = '0;
      slot_prio[i]  = '0;
    end
    pool_limit = vsa_pkg::ActiveReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_and_steal();
    test_finished_marks();
    test_bad_requests();
    test_empty_pool();
    test_backpressure();
    test_random_traffic(260, 7'd64);
    test_random_traffic(110, 7'd5);
    test_random_traffic(60, 7'd1);
    test_random_traffic(120, 7'd127);
    test_random_traffic(120, 7'd17);
    test_random_traffic(15, 7'd0);

    wait_quiet();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/vsa_pkg.sv
sv/vsa_ram.sv
sv/voice_slot_allocator_core.sv
sv/vsa_checker.sv
tb/sv/voice_slot_allocator_core_tb.sv
